/* hw/rtl/most_frequent_value_finder_macros.svh */
// ----------------------------------------------------------------------------
// most_frequent_value_finder_macros.svh
// Assertion macros shared by the mfv_cell and mfv_best modules.
// ----------------------------------------------------------------------------
`ifndef MOST_FREQUENT_VALUE_FINDER_MACROS_SVH
`define MOST_FREQUENT_VALUE_FINDER_MACROS_SVH

`ifndef SYNTHESIS
`define MFV_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define MFV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define MFV_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define MFV_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* hw/rtl/mfv_pkg.sv */
// ----------------------------------------------------------------------------
// mfv_pkg
// Types, sizes and helpers of the most frequent value finder.
// ----------------------------------------------------------------------------
package mfv_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int COUNT_BITS    = 16;
  localparam int VALUE_BITS    = 32;
  localparam int OUT_CNT_BITS  = 16;
  localparam int WIDE_BITS     = (COUNT_BITS > OUT_CNT_BITS) ? COUNT_BITS : OUT_CNT_BITS;

  localparam logic [COUNT_BITS-1:0]   COUNT_MAX   = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0]   COUNT_ONE   = COUNT_BITS'(1);
  localparam logic [OUT_CNT_BITS-1:0] OUT_CNT_MAX = {OUT_CNT_BITS{1'b1}};
  localparam logic [VALUE_BITS-1:0]   NO_VALUE    = {VALUE_BITS{1'b1}};

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic                         last;
  } mfv_in_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] mode_value;
    logic [OUT_CNT_BITS-1:0]      mode_count;
    logic                         overflow;
  } mfv_out_t;

  // beat travelling down the cell chain
  typedef struct packed {
    logic                         vld;
    logic                         last;
    logic                         hit;
    logic signed [VALUE_BITS-1:0] value;
    logic [COUNT_BITS-1:0]        cnt;
  } mfv_tok_t;

  function automatic logic [OUT_CNT_BITS-1:0] sat_out(input logic [COUNT_BITS-1:0] cnt);
    logic [WIDE_BITS-1:0] w;
    w = WIDE_BITS'(cnt);
    return (w > WIDE_BITS'(OUT_CNT_MAX)) ? OUT_CNT_MAX : OUT_CNT_BITS'(w);
  endfunction

endpackage

/* hw/rtl/mfv_cell.sv */
// ----------------------------------------------------------------------------
// mfv_cell
// One table entry: holds a key and its count, matches or claims a passing beat.
// ----------------------------------------------------------------------------
`include "most_frequent_value_finder_macros.svh"

module mfv_cell (
  input  logic             clk,
  input  logic             rst,
  input  mfv_pkg::mfv_tok_t tok_in,
  output mfv_pkg::mfv_tok_t tok_out
);
  import mfv_pkg::*;

  logic                         used;
  logic signed [VALUE_BITS-1:0] key;
  logic [COUNT_BITS-1:0]        count;

  logic                  open;
  logic                  hit_here;
  logic                  claim;
  logic [COUNT_BITS-1:0] count_inc;

  assign open      = tok_in.vld && !tok_in.hit;
  assign hit_here  = open && used && (key == tok_in.value);
  assign claim     = open && !used;
  assign count_inc = (count == COUNT_MAX) ? count : count + COUNT_ONE;

  // the last beat of a set frees the cell once it has passed
  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= 1'b0;
      tok_out <= '0;
    end else begin
      tok_out.vld   <= tok_in.vld;
      tok_out.last  <= tok_in.last;
      tok_out.value <= tok_in.value;
      tok_out.hit   <= tok_in.hit | hit_here | claim;
      tok_out.cnt   <= hit_here ? count_inc : (claim ? COUNT_ONE : tok_in.cnt);
      if (tok_in.vld) begin
        if (tok_in.last) begin
          used <= 1'b0;
        end else if (claim) begin
          used <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (claim) begin
      key   <= tok_in.value;
      count <= COUNT_ONE;
    end else if (hit_here) begin
      count <= count_inc;
    end
  end

  `MFV_ASSERT_NEXT(a_beat_moves, clk, rst, tok_in.vld, tok_out.vld)
  `MFV_ASSERT_NEXT(a_claim_holds, clk, rst, claim && !tok_in.last, used && tok_out.hit)

endmodule

/* hw/rtl/mfv_best.sv */
// ----------------------------------------------------------------------------
// mfv_best
// Chain tail: tracks the leading value and count, flags a full table, reports.
// ----------------------------------------------------------------------------
`include "most_frequent_value_finder_macros.svh"

module mfv_best (
  input  logic              clk,
  input  logic              rst,
  input  mfv_pkg::mfv_tok_t tok,
  output logic              done,
  output mfv_pkg::mfv_out_t result
);
  import mfv_pkg::*;

  logic signed [VALUE_BITS-1:0] best_value;
  logic [COUNT_BITS-1:0]        best_count;
  logic                         full;

  logic                         upd;
  logic signed [VALUE_BITS-1:0] best_value_next;
  logic [COUNT_BITS-1:0]        best_count_next;
  logic                         full_next;

  assign upd             = tok.vld && tok.hit && (tok.cnt > best_count);
  assign best_value_next = upd ? tok.value : best_value;
  assign best_count_next = upd ? tok.cnt : best_count;
  assign full_next       = full | (tok.vld & ~tok.hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      best_value <= NO_VALUE;
      best_count <= '0;
      full       <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= tok.vld && tok.last;
      if (tok.vld && tok.last) begin
        best_value <= NO_VALUE;
        best_count <= '0;
        full       <= 1'b0;
      end else begin
        best_value <= best_value_next;
        best_count <= best_count_next;
        full       <= full_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok.vld && tok.last) begin
      result.mode_value <= best_value_next;
      result.mode_count <= sat_out(best_count_next);
      result.overflow   <= full_next;
    end
  end

  `MFV_ASSERT_IMPL(a_done_count, clk, rst, done, result.mode_count != '0)
  `MFV_ASSERT_IMPL(a_cleared, clk, rst, done, best_count == '0 && !full)

endmodule

/* hw/rtl/most_frequent_value_finder.sv */
// ----------------------------------------------------------------------------
// most_frequent_value_finder
// Mode of a set of signed 32-bit values, computed by a chain of table cells.
// ----------------------------------------------------------------------------
// Usage:
//   Drive item (value, last) with start high; a beat is taken at every edge
//   with start high and busy low. busy stays low, so one beat per cycle.
//   Mark the final value of a set with last. Each beat walks the chain of
//   TABLE_ENTRIES cells, one cell per cycle: it bumps the matching cell or
//   claims the first free one. A value that finds no free cell sets overflow.
//   After the edge that takes its last beat, a set's result is registered once
//   in each of the TABLE_ENTRIES cells in turn and then in the tracker.
//   Output: done is high for exactly one cycle with result (mode_value,
//   mode_count, overflow); the receiver cannot stall and must take it then.
//   Ties go to the value that reached the top count first; counts saturate.
//   The last beat clears each cell as it passes, so the next set may follow
//   in the very next cycle.
//   Reset (rst, synchronous): empties all cells and the tracker.
// ----------------------------------------------------------------------------
module most_frequent_value_finder (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  mfv_pkg::mfv_in_t  item,
  output logic              done,
  output mfv_pkg::mfv_out_t result
);
  import mfv_pkg::*;

  mfv_tok_t tok [TABLE_ENTRIES+1];

  assign busy = 1'b0;

  always_comb begin
    tok[0].vld   = start & ~busy;
    tok[0].last  = item.last;
    tok[0].hit   = 1'b0;
    tok[0].value = item.value;
    tok[0].cnt   = '0;
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    mfv_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1])
    );
  end

  mfv_best u_best (
    .clk    (clk),
    .rst    (rst),
    .tok    (tok[TABLE_ENTRIES]),
    .done   (done),
    .result (result)
  );

endmodule

/* tb/most_frequent_value_finder_test.sv */
// ----------------------------------------------------------------------------
// most_frequent_value_finder_test
// Self-checking bench for the mode finder: sets of signed values go in as
// beats in random bursts. A scoreboard keeps its own value/count table and
// predicts mode, count and overflow for each set, then checks every result
// strobe against the oldest expected mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module most_frequent_value_finder_test;
  import mfv_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_BEATS = 1600;

  class mode_scoreboard;
    logic [VALUE_BITS-1:0] keys[TABLE_ENTRIES];
    logic [COUNT_BITS-1:0] counts[TABLE_ENTRIES];
    int unsigned           used;
    logic [VALUE_BITS-1:0] top_value;
    logic [COUNT_BITS-1:0] top_count;
    bit                    full_seen;
    mfv_out_t              modes_due[$];
    int                    errors;
    int                    beats;
    int                    sets;
    int                    overflow_sets;
    int                    saturated_sets;

    function new();
      clear_table();
    endfunction

    function void clear_table();
      used      = 0;
      top_value = NO_VALUE;
      top_count = '0;
      full_seen = 1'b0;
    endfunction

    function void note_beat(mfv_in_t b);
      int                    slot;
      logic [COUNT_BITS-1:0] hits;
      bit                    counted;
      mfv_out_t              due;
      slot    = -1;
      counted = 1'b1;
      hits    = '0;
      beats++;
      for (int i = 0; i < used; i++) begin
        if (keys[i] == b.value) begin
          slot = i;
          break;
        end
      end
      if (slot >= 0) begin
        if (counts[slot] != COUNT_MAX) counts[slot]++;
        hits = counts[slot];
      end else if (used < TABLE_ENTRIES) begin
        keys[used]   = b.value;
        counts[used] = COUNT_ONE;
        hits         = COUNT_ONE;
        used++;
      end else begin
        full_seen = 1'b1;
        counted   = 1'b0;
      end
      if (counted && hits > top_count) begin
        top_count = hits;
        top_value = b.value;
      end
      if (b.last) begin
        due.mode_value = top_value;
        due.mode_count = (top_count > OUT_CNT_MAX) ? OUT_CNT_MAX : OUT_CNT_BITS'(top_count);
        due.overflow   = full_seen;
        modes_due.push_back(due);
        sets++;
        if (full_seen) overflow_sets++;
        if (top_count == COUNT_MAX) saturated_sets++;
        clear_table();
      end
    endfunction

    function void check_result(mfv_out_t got);
      mfv_out_t want;
      if (modes_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual value %0d count %0d ovf %0b",
                 $time, got.mode_value, got.mode_count, got.overflow);
        return;
      end
      want = modes_due.pop_front();
      if (got.mode_value !== want.mode_value) begin
        errors++;
        $display("%0t: mode_value mismatch, expected %0d actual %0d",
                 $time, want.mode_value, got.mode_value);
      end
      if (got.mode_count !== want.mode_count) begin
        errors++;
        $display("%0t: mode_count mismatch, expected %0d actual %0d",
                 $time, want.mode_count, got.mode_count);
      end
      if (got.overflow !== want.overflow) begin
        errors++;
        $display("%0t: overflow mismatch, expected %0b actual %0b",
                 $time, want.overflow, got.overflow);
      end
    endfunction
  endclass

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  mfv_in_t  item;
  logic     done;
  mfv_out_t result;

  mode_scoreboard sb = new();
  int             idle_cycles;
  int             burst_left;

  most_frequent_value_finder u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // check before noting, so a result strobe meets the older expectation
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(result);
      if (start && !busy) sb.note_beat(item);
      if (done || (start && !busy)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no beat or result for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // called at a falling edge; returns at a falling edge
  task automatic send_beat(input logic signed [VALUE_BITS-1:0] v, input bit is_last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    if (burst_left > 0) burst_left--;
    item.value <= v;
    item.last  <= is_last;
    start      <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic send_set(input logic signed [VALUE_BITS-1:0] vals[$]);
    foreach (vals[i]) send_beat(vals[i], i == vals.size() - 1);
  endtask

  task automatic wait_all_modes();
    start <= 1'b0;
    @(negedge clk);
    while (sb.modes_due.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return -32'sd1;
      3:       return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic signed [VALUE_BITS-1:0] vals[$];
    logic signed [VALUE_BITS-1:0] pool[$];
    logic signed [VALUE_BITS-1:0] base;
    int                           n;
    int                           kind;
    rst         = 1'b1;
    start       = 1'b0;
    item        = '0;
    idle_cycles = 0;
    burst_left  = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // single-beat sets at the extremes, repeats, and ties
    send_set('{32'sh8000_0000});
    send_set('{32'sh7fff_ffff});
    send_set('{32'sd0});
    send_set('{-32'sd1, 32'sd0, -32'sd1});
    send_set('{32'sd3, 32'sd9, 32'sd9, 32'sd3});
    send_set('{32'sd4, 32'sd6});
    send_set('{32'sh5555_5555, 32'shaaaa_aaaa, 32'shaaaa_aaaa, 32'sh5555_5555,
               32'sh5555_5555});
    wait_all_modes();

    // table exactly full, then one distinct value too many
    vals = {};
    for (int i = 0; i < TABLE_ENTRIES; i++) vals.push_back(32'sd1000 + i);
    vals.push_back(32'sd1000 + TABLE_ENTRIES - 1);
    send_set(vals);
    vals = {};
    for (int i = 0; i <= TABLE_ENTRIES; i++) vals.push_back(-32'sd500 - i);
    send_set(vals);
    wait_all_modes();

    while (sb.beats < RANDOM_BEATS) begin
      vals = {};
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        pool = {};
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) pool.push_back(pick_value());
        n = $urandom_range(1, 40);
        for (int i = 0; i < n; i++) vals.push_back(pool[$urandom_range(0, pool.size() - 1)]);
      end else if (kind < 82) begin
        n = $urandom_range(1, 20);
        for (int i = 0; i < n; i++) vals.push_back(pick_value());
      end else if (kind < 95) begin
        base = $urandom;
        n = $urandom_range(TABLE_ENTRIES - 2, TABLE_ENTRIES + 25);
        for (int i = 0; i < n; i++) begin
          if (i > 0 && $urandom_range(0, 3) == 0)
            vals.push_back(vals[$urandom_range(0, i - 1)]);
          else
            vals.push_back(base + i);
        end
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) vals.push_back(32'sd42);
      end
      send_set(vals);
      if ($urandom_range(0, 40) == 0) wait_all_modes();
    end

    wait_all_modes();
    repeat (TABLE_ENTRIES + 8) @(negedge clk);
    $display("Covered %0d beats in %0d sets: %0d with table overflow, %0d with a saturated count.",
             sb.beats, sb.sets, sb.overflow_sets, sb.saturated_sets);
    if (sb.errors == 0 && sb.modes_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/mfv_pkg.sv
hw/rtl/mfv_cell.sv
hw/rtl/mfv_best.sv
hw/rtl/most_frequent_value_finder.sv
tb/most_frequent_value_finder_test.sv
